@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion macros used by plst_ctrl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/plst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg
// Types and constants shared by the positional list store.
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VAL_W            = 32;
    localparam int POS_W            = 8;
    localparam int CMD_W            = 3;
    localparam int STAT_W           = 3;
    localparam int LEN_W            = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_POS   = 3'd1,
        CMD_INS_END   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_POS   = 3'd4,
        CMD_DEL_END   = 3'd5,
        CMD_READ_ALL  = 3'd6
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_RANGE   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_ROT  = 2'd3
    } cell_op_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } plst_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] element;
        logic                    element_valid;
        logic                    last;
        logic [LEN_W-1:0]        length;
    } plst_out_t;

    typedef struct packed {
        cell_op_t                op;
        logic signed [VAL_W-1:0] value;
    } cell_ctrl_t;

endpackage

@@ hdl/plst_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_cell
// One list slot: holds, loads, or takes its left, right or head neighbor.
// ----------------------------------------------------------------------------
module plst_cell
    import plst_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
)(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic [IDX_W-1:0]        idx,
    input  logic [IDX_W-1:0]        last_idx,
    input  logic signed [VAL_W-1:0] left_data,
    input  logic signed [VAL_W-1:0] right_data,
    input  logic signed [VAL_W-1:0] head_data,
    output logic signed [VAL_W-1:0] data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            OP_INS:
            begin
                if (MY_IDX == idx)
                begin
                    data_next = ctrl.value;
                end
                else if (MY_IDX > idx)
                begin
                    data_next = left_data;
                end
            end
            OP_DEL:
            begin
                if (MY_IDX >= idx)
                begin
                    data_next = right_data;
                end
            end
            OP_ROT:
            begin
                if (MY_IDX == last_idx)
                begin
                    data_next = head_data;
                end
                else if (MY_IDX < last_idx)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ hdl/plst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_ctrl
// Command decode, element count, read-out sequencing and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plst_ctrl
    import plst_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  plst_in_t                cmd,
    output logic                    res_valid,
    input  logic                    res_ready,
    output plst_out_t               res,
    input  logic signed [VAL_W-1:0] head_data,
    output cell_ctrl_t              cell_ctrl,
    output logic [IDX_W-1:0]        cell_idx,
    output logic [IDX_W-1:0]        last_idx
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             res_valid_reg, res_valid_next;
    plst_out_t        res_reg, res_next;

    logic             res_free;
    logic             cmd_fire;
    logic             full;
    logic             empty;
    logic             rd_last;
    logic [CNT_W-1:0] cnt_m1;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] pos_m1;
    logic [CMP_W-1:0] cnt_ext;
    status_t          status;

    assign res_free  = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE) && res_free;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign full      = (count_reg == CAP_CNT);
    assign empty     = (count_reg == '0);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign pos_ext   = CMP_W'(cmd.position);
    assign pos_m1    = pos_ext - CMP_W'(1);
    assign cnt_ext   = CMP_W'(count_reg);
    assign last_idx  = cnt_m1[IDX_W-1:0];
    assign rd_last   = (rd_cnt_reg == last_idx);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire && (cmd.command == CMD_READ_ALL) && !empty)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (res_free && rd_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        cell_ctrl.op    = OP_HOLD;
        cell_ctrl.value = cmd.value;
        cell_idx        = '0;
        count_next      = count_reg;
        rd_cnt_next     = rd_cnt_reg;
        status          = ST_OK;
        res_valid_next  = res_valid_reg && !res_ready;
        res_next        = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                rd_cnt_next = '0;
                if (cmd_fire)
                begin
                    case (cmd.command)
                        CMD_INS_FRONT:
                        begin
                            if (full)
                            begin
                                status = ST_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op = OP_INS;
                                count_next   = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_INS_POS:
                        begin
                            if (pos_ext == '0)
                            begin
                                status = ST_INVALID;
                            end
                            else if (full)
                            begin
                                status = ST_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op = OP_INS;
                                count_next   = count_reg + CNT_W'(1);
                                if (pos_ext > cnt_ext)
                                begin
                                    cell_idx = count_reg[IDX_W-1:0];
                                end
                                else
                                begin
                                    cell_idx = pos_m1[IDX_W-1:0];
                                end
                            end
                        end
                        CMD_INS_END:
                        begin
                            if (full)
                            begin
                                status = ST_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op = OP_INS;
                                cell_idx     = count_reg[IDX_W-1:0];
                                count_next   = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                status = ST_EMPTY;
                            end
                            else
                            begin
                                cell_ctrl.op = OP_DEL;
                                count_next   = cnt_m1;
                            end
                        end
                        CMD_DEL_POS:
                        begin
                            if (pos_ext == '0)
                            begin
                                status = ST_INVALID;
                            end
                            else if (empty)
                            begin
                                status = ST_EMPTY;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                status = ST_RANGE;
                            end
                            else
                            begin
                                cell_ctrl.op = OP_DEL;
                                cell_idx     = pos_m1[IDX_W-1:0];
                                count_next   = cnt_m1;
                            end
                        end
                        CMD_DEL_END:
                        begin
                            if (empty)
                            begin
                                status = ST_EMPTY;
                            end
                            else
                            begin
                                cell_ctrl.op = OP_DEL;
                                cell_idx     = last_idx;
                                count_next   = cnt_m1;
                            end
                        end
                        CMD_READ_ALL:
                        begin
                            status = ST_OK;
                        end
                        default:
                        begin
                            status = ST_INVALID;
                        end
                    endcase
                    // every command yields one result here except a non-empty read-out
                    if (!((cmd.command == CMD_READ_ALL) && !empty))
                    begin
                        res_valid_next         = 1'b1;
                        res_next.status        = status;
                        res_next.element       = '0;
                        res_next.element_valid = 1'b0;
                        res_next.last          = 1'b1;
                        res_next.length        = LEN_W'(count_next);
                    end
                end
            end
            S_READ:
            begin
                if (res_free)
                begin
                    // emit head, then rotate the occupied cells by one
                    cell_ctrl.op           = OP_ROT;
                    rd_cnt_next            = rd_last ? '0 : rd_cnt_reg + IDX_W'(1);
                    res_valid_next         = 1'b1;
                    res_next.status        = ST_OK;
                    res_next.element       = head_data;
                    res_next.element_valid = 1'b1;
                    res_next.last          = rd_last;
                    res_next.length        = LEN_W'(count_reg);
                end
            end
            default:
            begin
                cell_ctrl.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CAP_CNT)
    `ASSERT_NEXT(a_cmd_answered, clk, rst_n, cmd_fire, res_valid_reg || (state_reg == S_READ))
    `ASSERT_IMPLIES(a_read_in_range, clk, rst_n, state_reg == S_READ, CNT_W'(rd_cnt_reg) < count_reg)
    `ASSERT_IMPLIES(a_read_not_last, clk, rst_n, res_valid_reg && (state_reg == S_READ), !res_reg.last)

endmodule

@@ hdl/positional_list_store_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_top
// Bounded ordered list of signed values held in a chain of cells.
// ----------------------------------------------------------------------------
//  channel | signals                     | transfer
//  --------+-----------------------------+------------------------------
//  command | cmd_valid, cmd_ready, cmd   | one command per transfer
//  result  | res_valid, res_ready, res   | one result item per transfer
//
//  edits shift all cells at once, one result per command
//  read-all of n elements: one result per cycle while results are taken,
//  read out by rotating the cell chain through the head cell
//  reset clears the count and control state; cell contents are undefined until written
//  a stalled result holds its register and blocks new commands
// ----------------------------------------------------------------------------
module positional_list_store_top
    import plst_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  plst_in_t  cmd,
    output logic      res_valid,
    input  logic      res_ready,
    output plst_out_t res
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctrl_t              cell_ctrl;
    logic [IDX_W-1:0]        cell_idx;
    logic [IDX_W-1:0]        last_idx;
    logic signed [VAL_W-1:0] cell_data [CAPACITY];

    plst_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .head_data (cell_data[0]),
        .cell_ctrl (cell_ctrl),
        .cell_idx  (cell_idx),
        .last_idx  (last_idx)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        plst_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .idx        (cell_idx),
            .last_idx   (last_idx),
            .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

endmodule

@@ sim/positional_list_store_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_top_test
// Self-checking bench for the positional list store. A driver feeds commands
// from a queue, a monitor tracks the list contents as a queue of values and
// checks every result item against the predicted status, element, flags and length.
// ----------------------------------------------------------------------------
module positional_list_store_top_test;
    import plst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int               LIST_CAP   = DEFAULT_CAPACITY;
    localparam int unsigned      CYCLE_LIMIT = 400000;
    localparam int               DRAIN_CYCLES = 2 * LIST_CAP + 20;
    localparam int unsigned      QUIET_FROM = 70;
    localparam int unsigned      QUIET_TO   = 135;

    typedef struct {
        plst_in_t item;
        bit       drain_first;
    } pending_cmd_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    plst_in_t  cmd = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    plst_out_t res;

    pending_cmd_t            pending_cmds[$];
    logic signed [VAL_W-1:0] list_values[$];
    plst_out_t               expected_results[$];
    int unsigned             cmd_accepts = 0;
    int unsigned             cmd_issued = 0;
    int unsigned             cycle_count = 0;
    int unsigned             mismatches = 0;
    pending_cmd_t            next_cmd;
    plst_out_t               want;

    positional_list_store_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #5 clk = ~clk;

    // list model

    function automatic void queue_result(status_t st, logic signed [VAL_W-1:0] elem,
                                         logic elem_valid, logic is_last);
        plst_out_t r;
        r.status        = st;
        r.element       = elem;
        r.element_valid = elem_valid;
        r.last          = is_last;
        r.length        = LEN_W'(list_values.size());
        expected_results.push_back(r);
    endfunction

    function automatic status_t list_insert(int unsigned idx, logic signed [VAL_W-1:0] v);
        if (list_values.size() >= LIST_CAP)
            return ST_FULL;
        if (idx > list_values.size())
            idx = list_values.size();
        list_values.insert(idx, v);
        return ST_OK;
    endfunction

    function automatic void list_apply(plst_in_t c);
        status_t     st;
        int unsigned n;
        int unsigned pos;
        n   = list_values.size();
        pos = 32'(c.position);
        st  = ST_OK;
        case (c.command)
            CMD_INS_FRONT: st = list_insert(0, c.value);
            CMD_INS_POS:
            begin
                if (pos == 0)
                    st = ST_INVALID;
                else
                    st = list_insert(pos - 1, c.value);
            end
            CMD_INS_END: st = list_insert(n, c.value);
            CMD_DEL_FRONT:
            begin
                if (n == 0)
                    st = ST_EMPTY;
                else
                    list_values.delete(0);
            end
            CMD_DEL_POS:
            begin
                if (pos == 0)
                    st = ST_INVALID;
                else if (n == 0)
                    st = ST_EMPTY;
                else if (pos > n)
                    st = ST_RANGE;
                else
                    list_values.delete(pos - 1);
            end
            CMD_DEL_END:
            begin
                if (n == 0)
                    st = ST_EMPTY;
                else
                    list_values.delete(n - 1);
            end
            CMD_READ_ALL:
            begin
                if (n == 0)
                    queue_result(ST_OK, '0, 1'b0, 1'b1);
                for (int i = 0; i < n; i++)
                    queue_result(ST_OK, list_values[i], 1'b1, (i == n - 1));
                return;
            end
            default: st = ST_INVALID;
        endcase
        queue_result(st, '0, 1'b0, 1'b1);
    endfunction

    // stimulus helpers

    function automatic void add_cmd(logic [CMD_W-1:0] c, logic signed [VAL_W-1:0] v,
                                    logic [POS_W-1:0] p, bit drain = 1'b0);
        pending_cmd_t pc;
        pc.item.command  = c;
        pc.item.value    = v;
        pc.item.position = p;
        pc.drain_first   = drain;
        pending_cmds.push_back(pc);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return {1'b1, {(VAL_W-1){1'b0}}};
            1: return {1'b0, {(VAL_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int hi);
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return '0;
        if (sel < 25)
            return POS_W'($urandom_range(255));
        return POS_W'($urandom_range(hi, 1));
    endfunction

    function automatic logic [CMD_W-1:0] pick_mixed_cmd();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) return CMD_INS_FRONT;
        if (sel < 31) return CMD_INS_POS;
        if (sel < 46) return CMD_INS_END;
        if (sel < 57) return CMD_DEL_FRONT;
        if (sel < 71) return CMD_DEL_POS;
        if (sel < 82) return CMD_DEL_END;
        if (sel < 97) return CMD_READ_ALL;
        return CMD_UNUSED;
    endfunction

    function automatic bit take_break();
        if (cmd_accepts >= QUIET_FROM && cmd_accepts < QUIET_TO)
            return 1'b0;
        return ($urandom_range(99) < 9);
    endfunction

    // driver

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            res_ready <= !take_break();
            if (!cmd_valid || cmd_accepts == cmd_issued)
            begin
                if (pending_cmds.size() != 0 && !take_break()
                    && !(pending_cmds[0].drain_first && expected_results.size() != 0))
                begin
                    next_cmd = pending_cmds.pop_front();
                    cmd       <= next_cmd.item;
                    cmd_valid <= 1'b1;
                    cmd_issued = cmd_issued + 1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                cmd_accepts = cmd_accepts + 1;
                list_apply(cmd);
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transfer: status %0d element %0d ev %0b last %0b len %0d",
                                 res.status, res.element, res.element_valid, res.last, res.length);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.status !== want.status || res.element !== want.element
                        || res.element_valid !== want.element_valid
                        || res.last !== want.last || res.length !== want.length)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("result mismatch at cycle %0d", cycle_count);
                            $display("  expected: status %0d element %0d ev %0b last %0b len %0d",
                                     want.status, want.element, want.element_valid,
                                     want.last, want.length);
                            $display("  actual:   status %0d element %0d ev %0b last %0b len %0d",
                                     res.status, res.element, res.element_valid,
                                     res.last, res.length);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** positional_list_store_top: FAILED **");
            $finish;
        end
    end

    // stimulus and end of run

    initial
    begin
        // empty list cases
        add_cmd(CMD_READ_ALL, '0, '0);
        add_cmd(CMD_DEL_FRONT, '0, '0);
        add_cmd(CMD_DEL_POS, '0, 8'd1);
        add_cmd(CMD_DEL_END, '0, '0);
        add_cmd(CMD_DEL_POS, '0, 8'd0);
        add_cmd(CMD_INS_POS, 32'sd7, 8'd0);
        // positional inserts: into empty, front, append past end, middle
        add_cmd(CMD_INS_POS, 32'sh7fffffff, 8'd5);
        add_cmd(CMD_INS_FRONT, 32'sh80000000, '0);
        add_cmd(CMD_INS_END, 32'sd0, 8'hff);
        add_cmd(CMD_INS_POS, -32'sd1, 8'd1);
        add_cmd(CMD_INS_POS, 32'sh5a5a5a5a, 8'd255);
        add_cmd(CMD_INS_POS, 32'sh12345678, 8'd3);
        add_cmd(CMD_READ_ALL, '0, '0);
        // deletes: out of range, last, middle, an unused command, front, end
        add_cmd(CMD_DEL_POS, '0, 8'd200);
        add_cmd(CMD_DEL_POS, '0, 8'd7);
        add_cmd(CMD_DEL_POS, '0, 8'd6);
        add_cmd(CMD_DEL_POS, '0, 8'd2);
        add_cmd(CMD_UNUSED, 32'sh0f0f0f0f, 8'hff);
        add_cmd(CMD_DEL_FRONT, '0, '0);
        add_cmd(CMD_DEL_END, '0, '0);
        add_cmd(CMD_READ_ALL, '0, '0);

        // random mix
        for (int i = 0; i < 40; i++)
            add_cmd(pick_mixed_cmd(), pick_value(), pick_position(12), (i == 0));

        // fill to capacity, then hit the full list
        for (int i = 0; i < LIST_CAP + 4; i++)
        begin
            case ($urandom_range(2))
                0: add_cmd(CMD_INS_FRONT, pick_value(), pick_position(70));
                1: add_cmd(CMD_INS_POS, pick_value(), POS_W'($urandom_range(LIST_CAP + 6, 1)));
                default: add_cmd(CMD_INS_END, pick_value(), pick_position(70));
            endcase
        end
        add_cmd(CMD_INS_POS, pick_value(), 8'd0);
        add_cmd(CMD_INS_POS, pick_value(), 8'd1);
        add_cmd(CMD_INS_FRONT, pick_value(), '0);
        add_cmd(CMD_INS_END, pick_value(), '0);
        add_cmd(CMD_READ_ALL, '0, '0, 1'b1);

        // delete-heavy stretch
        for (int i = 0; i < 25; i++)
        begin
            case ($urandom_range(3))
                0: add_cmd(CMD_DEL_FRONT, pick_value(), pick_position(70));
                1: add_cmd(CMD_DEL_END, pick_value(), pick_position(70));
                default: add_cmd(CMD_DEL_POS, pick_value(), pick_position(LIST_CAP + 4));
            endcase
        end

        // random mix
        for (int i = 0; i < 30; i++)
            add_cmd(pick_mixed_cmd(), pick_value(), pick_position(45), (i == 0));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("** positional_list_store_top: PASSED **");
        else
            $display("** positional_list_store_top: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/plst_pkg.sv
hdl/plst_cell.sv
hdl/plst_ctrl.sv
hdl/positional_list_store_top.sv
sim/positional_list_store_top_test.sv
